>>> rtl/owm_pkg.sv
// Shared types and constants for the 1-Wire bus master.
package owm_pkg;

  typedef enum logic [1:0] {
    ACT_TICK  = 2'd0,
    ACT_RESET = 2'd1,
    ACT_WRITE = 2'd2,
    ACT_READ  = 2'd3
  } action_t;

  typedef enum logic [2:0] {
    PH_IDLE    = 3'd0,
    PH_RST_LOW = 3'd1,
    PH_RST_REL = 3'd2,
    PH_LOW     = 3'd3,
    PH_MID     = 3'd4,
    PH_END     = 3'd5
  } phase_t;

  typedef enum logic [2:0] {
    REG_RESET_TIME     = 3'd0,
    REG_WRITE_ONE_LOW  = 3'd1,
    REG_SLOT_TIME      = 3'd2,
    REG_RECOVERY_TIME  = 3'd3,
    REG_SAMPLE_DELAY   = 3'd4
  } reg_idx_t;

  localparam logic [7:0] CRC_POLY = 8'h8C;

  localparam logic [9:0] RESET_TIME_DEF    = 10'd500;
  localparam logic [7:0] WRITE_ONE_LOW_DEF = 8'd5;
  localparam logic [7:0] SLOT_TIME_DEF     = 8'd80;
  localparam logic [7:0] RECOVERY_DEF      = 8'd5;
  localparam logic [7:0] SAMPLE_DELAY_DEF  = 8'd8;

  localparam logic [3:0] BITS_PER_BYTE = 4'd8;

  typedef struct packed {
    logic       rejected;
    logic [7:0] crc_value;
    logic [7:0] read_data;
    logic       done_res;
    logic       busy_res;
    logic       drive_low;
  } result_t;

endpackage

>>> rtl/onewire_bus_master.sv
// 1-Wire bus master: tick-driven slot timing, byte shifter and Dallas CRC-8.
// Each transfer yields one result transfer, held in the result register or,
// while the output stalls, in the skid register. One item is taken every cycle
// while the skid register is empty; this two-entry output keeps input ready
// while a result waits. Synchronous active-high reset returns to idle with
// timing registers at their default values, CRC, shifter and read byte cleared.
module onewire_bus_master
  import owm_pkg::*;
#(
  parameter int TIMER_BITS = 10
) (
  input  logic        clk,
  input  logic        rst,
  // s_tdata: data_byte[7:0], line_level[8], zero[15:9]
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [15:0] s_tdata,
  // s_tuser: action[1:0]
  input  logic [1:0]  s_tuser,
  // m_tdata: drive_low[0], busy_res[1], done_res[2], read_data[10:3],
  //          crc_value[18:11], rejected[19], zero[23:20]
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [23:0] m_tdata,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [4:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  logic [9:0] reset_time;
  logic [7:0] write_one_low_time;
  logic [7:0] slot_time;
  logic [7:0] recovery_time;
  logic [7:0] sample_delay;

  phase_t                  phase, phase_next;
  logic [TIMER_BITS-1:0]   phase_timer, phase_timer_next;
  logic [7:0]              shift_byte, shift_byte_next;
  logic [3:0]              bits_left, bits_left_next;
  logic                    reading, reading_next;
  logic [7:0]              crc_reg, crc_reg_next;
  logic [7:0]              read_latch, read_latch_next;
  logic                    done, rej, fb, in_bit;
  logic [9:0]              bit_dur;

  action_t   action;
  logic [7:0] data_byte;
  logic       line_level;
  logic       accept;
  reg_idx_t   cfg_idx;
  result_t    res_new, out_reg, skid;
  logic       skid_valid;

  assign action     = action_t'(s_tuser);
  assign data_byte  = s_tdata[7:0];
  assign line_level = s_tdata[8];
  assign accept     = s_tvalid && s_tready;
  assign s_tready   = !skid_valid;

  // configuration port
  assign pready  = 1'b1;
  assign cfg_idx = reg_idx_t'(paddr[4:2]);

  always_ff @(posedge clk) begin
    if (rst) begin
      reset_time         <= RESET_TIME_DEF;
      write_one_low_time <= WRITE_ONE_LOW_DEF;
      slot_time          <= SLOT_TIME_DEF;
      recovery_time      <= RECOVERY_DEF;
      sample_delay       <= SAMPLE_DELAY_DEF;
    end else if (psel && penable && pwrite && pready) begin
      unique case (cfg_idx)
        REG_RESET_TIME:    reset_time         <= pwdata[9:0];
        REG_WRITE_ONE_LOW: write_one_low_time <= pwdata[7:0];
        REG_SLOT_TIME:     slot_time          <= pwdata[7:0];
        REG_RECOVERY_TIME: recovery_time      <= pwdata[7:0];
        REG_SAMPLE_DELAY:  sample_delay       <= pwdata[7:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (cfg_idx)
      REG_RESET_TIME:    prdata = {22'd0, reset_time};
      REG_WRITE_ONE_LOW: prdata = {24'd0, write_one_low_time};
      REG_SLOT_TIME:     prdata = {24'd0, slot_time};
      REG_RECOVERY_TIME: prdata = {24'd0, recovery_time};
      REG_SAMPLE_DELAY:  prdata = {24'd0, sample_delay};
      default:           prdata = 32'd0;
    endcase
  end

  // per-item state update
  always_comb begin
    phase_next       = phase;
    phase_timer_next = phase_timer;
    shift_byte_next  = shift_byte;
    bits_left_next   = bits_left;
    reading_next     = reading;
    crc_reg_next     = crc_reg;
    read_latch_next  = read_latch;
    done             = 1'b0;
    rej              = 1'b0;
    in_bit           = line_level;
    fb               = crc_reg[0] ^ line_level;
    bit_dur          = 10'd0;

    if (action == ACT_TICK) begin
      if (phase != PH_IDLE) begin
        if (phase_timer > TIMER_BITS'(1)) begin
          phase_timer_next = phase_timer - TIMER_BITS'(1);
        end else begin
          unique case (phase)
            PH_RST_LOW: begin
              phase_next       = PH_RST_REL;
              phase_timer_next = TIMER_BITS'(reset_time);
            end
            PH_RST_REL: begin
              phase_next       = PH_IDLE;
              phase_timer_next = '0;
              done             = 1'b1;
            end
            PH_LOW: begin
              phase_next = reading ? PH_MID : (shift_byte[0] ? PH_MID : PH_END);
              if (reading)            bit_dur = {2'd0, sample_delay};
              else if (shift_byte[0]) bit_dur = {2'd0, slot_time};
              else                    bit_dur = {2'd0, recovery_time};
              phase_timer_next = TIMER_BITS'(bit_dur);
            end
            PH_MID: begin
              phase_next = PH_END;
              if (reading) begin
                shift_byte_next  = {in_bit, shift_byte[7:1]};
                crc_reg_next     = {1'b0, crc_reg[7:1]} ^ (fb ? CRC_POLY : 8'd0);
                phase_timer_next = TIMER_BITS'(slot_time);
              end else begin
                phase_timer_next = TIMER_BITS'(recovery_time);
              end
            end
            PH_END: begin
              if (!reading) shift_byte_next = {1'b0, shift_byte[7:1]};
              bits_left_next = bits_left - 4'd1;
              if (bits_left_next == 4'd0) begin
                if (reading) read_latch_next = shift_byte_next;
                phase_next       = PH_IDLE;
                phase_timer_next = '0;
                done             = 1'b1;
              end else begin
                if (reading)                 bit_dur = {2'd0, recovery_time};
                else if (shift_byte_next[0]) bit_dur = {2'd0, write_one_low_time};
                else                         bit_dur = {2'd0, slot_time};
                phase_next       = PH_LOW;
                phase_timer_next = TIMER_BITS'(bit_dur);
              end
            end
            default: begin
              phase_next       = PH_IDLE;
              phase_timer_next = '0;
            end
          endcase
        end
      end
    end else if (phase != PH_IDLE) begin
      rej = 1'b1;
    end else if (action == ACT_RESET) begin
      crc_reg_next     = 8'd0;
      reading_next     = 1'b0;
      phase_next       = PH_RST_LOW;
      phase_timer_next = TIMER_BITS'(reset_time);
    end else begin
      reading_next    = (action == ACT_READ);
      shift_byte_next = (action == ACT_READ) ? 8'd0 : data_byte;
      bits_left_next  = BITS_PER_BYTE;
      if (action == ACT_READ)   bit_dur = {2'd0, recovery_time};
      else if (data_byte[0])    bit_dur = {2'd0, write_one_low_time};
      else                      bit_dur = {2'd0, slot_time};
      phase_next       = PH_LOW;
      phase_timer_next = TIMER_BITS'(bit_dur);
    end

    res_new.drive_low = (phase_next == PH_RST_LOW) || (phase_next == PH_LOW);
    res_new.busy_res  = (phase_next != PH_IDLE);
    res_new.done_res  = done;
    res_new.read_data = read_latch_next;
    res_new.crc_value = crc_reg_next;
    res_new.rejected  = rej;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase       <= PH_IDLE;
      phase_timer <= '0;
      shift_byte  <= 8'd0;
      bits_left   <= 4'd0;
      reading     <= 1'b0;
      crc_reg     <= 8'd0;
      read_latch  <= 8'd0;
    end else if (accept) begin
      phase       <= phase_next;
      phase_timer <= phase_timer_next;
      shift_byte  <= shift_byte_next;
      bits_left   <= bits_left_next;
      reading     <= reading_next;
      crc_reg     <= crc_reg_next;
      read_latch  <= read_latch_next;
    end
  end

  // result register and skid
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid   <= 1'b0;
      skid_valid <= 1'b0;
    end else if (!m_tvalid || m_tready) begin
      if (skid_valid) begin
        m_tvalid   <= 1'b1;
        skid_valid <= 1'b0;
      end else begin
        m_tvalid <= accept;
      end
    end else if (accept) begin
      skid_valid <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!m_tvalid || m_tready) begin
      if (skid_valid) out_reg <= skid;
      else if (accept) out_reg <= res_new;
    end else if (accept) begin
      skid <= res_new;
    end
  end

  assign m_tdata = {4'd0, out_reg};

endmodule
